// ===== hw/rtl/ifmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer field formatter package
// Item types, conversion codes, character constants and the digit-to-ASCII
// mapping shared by the formatter modules.
// ----------------------------------------------------------------------------
package ifmt_pkg;

	localparam logic [5:0] MAX_FIELD = 6'd60;
	localparam int         VAL_W     = 32;
	localparam int         NUM_DIG   = 10;
	localparam int         CNT_W     = 7;

	localparam logic [1:0] CONV_SDEC = 2'd0;
	localparam logic [1:0] CONV_UDEC = 2'd1;
	localparam logic [1:0] CONV_HEXL = 2'd2;
	localparam logic [1:0] CONV_HEXU = 2'd3;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_LOWER = 8'h61;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  conversion;
		logic [5:0]  field_width;
		logic [5:0]  min_digits;
		logic        has_dot;
		logic        zero_pad;
		logic        left_align;
	} arg_t;

	typedef struct packed {
		logic [7:0]  char_code;
		logic        last;
		logic [31:0] total_count;
	} chr_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UPPER : CH_LOWER;
		if (d < 4'd10) begin
			return CH_ZERO + {4'h0, d};
		end else begin
			return base + {4'h0, d} - 8'd10;
		end
	endfunction

endpackage

// ===== hw/rtl/ifmt_bcd.sv =====
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Shift-and-add-three conversion of a 32-bit word into ten decimal digits,
// one input bit per cycle.
// ----------------------------------------------------------------------------
module ifmt_bcd (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ifmt_pkg::VAL_W-1:0]       bin,
	output logic                             busy,
	output logic [4*ifmt_pkg::NUM_DIG-1:0]   bcd
);
	import ifmt_pkg::*;

	localparam int STEP_W = $clog2(VAL_W + 1);

	logic [STEP_W-1:0]      cnt_q;
	logic [VAL_W-1:0]       bin_q;
	logic [4*NUM_DIG-1:0]   bcd_q;
	logic [4*NUM_DIG-1:0]   adj;

	always_comb begin
		for (int i = 0; i < NUM_DIG; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEP_W'(VAL_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[4*NUM_DIG-2:0], bin_q[VAL_W-1]};
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
		end
	end

	assign busy = (cnt_q != '0);
	assign bcd  = bcd_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> cnt_q == '0)
		else $error("conversion started while busy");

endmodule

// ===== hw/rtl/integer_field_formatter.sv =====
// ----------------------------------------------------------------------------
// Integer field formatter
// Formats one 32-bit integer as a printf-style decimal or hex field and emits
// it one ASCII character per item, last character marked, with a running
// character count.
// ----------------------------------------------------------------------------
// Sequence: decimal items pass through the bit-serial BCD converter (one
// bit per cycle), then the planning state; hex items skip the converter.
// Flow: a new item is taken only when idle, after the last one is emitted;
// within a segment, one character per cycle when the sink keeps up.
// Reset: arst_n clears the sequencer, output valid and the character count;
// payload and digit registers are not reset.
// ----------------------------------------------------------------------------
module integer_field_formatter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           arg_valid,
	output logic           arg_ready,
	input  ifmt_pkg::arg_t arg,
	output logic           chr_valid,
	input  logic           chr_ready,
	output ifmt_pkg::chr_t chr
);
	import ifmt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_PLAN = 3'd2;
	localparam logic [2:0] S_LSP  = 3'd3;
	localparam logic [2:0] S_SIGN = 3'd4;
	localparam logic [2:0] S_ZERO = 3'd5;
	localparam logic [2:0] S_DIG  = 3'd6;
	localparam logic [2:0] S_RSP  = 3'd7;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     rem_q;
	logic [31:0]          count_q;
	logic                 chr_valid_q;
	chr_t                 chr_q;

	logic                 neg_q, upper_q, dot_q, zp_q, la_q, show_q;
	logic [5:0]           w_q, p_q;
	logic [4*NUM_DIG-1:0] digits_q;
	logic [CNT_W-1:0]     zeros_q, space_q;
	logic [3:0]           ndig_q;

	logic                 accept, is_dec, neg_c, start, conv_busy;
	logic [VAL_W-1:0]     mag_c;
	logic [4*NUM_DIG-1:0] bcd;

	logic [3:0]           nd_c;
	logic                 any_c, show_c, zeff_c;
	logic [CNT_W-1:0]     len_c, prec_c, w7, zeros_c, tot_c, space_c, rem_c;

	logic                 emit_st, slot_free, load, advance;
	logic [2:0]           nxt_state;
	logic [CNT_W-1:0]     nxt_cnt;
	logic [3:0]           dig_idx;
	logic [7:0]           ch;

	// accept side
	assign arg_ready = (state_q == S_IDLE);
	assign accept    = arg_valid && arg_ready;
	assign is_dec    = (arg.conversion == CONV_SDEC) || (arg.conversion == CONV_UDEC);
	assign neg_c     = (arg.conversion == CONV_SDEC) && arg.value[VAL_W-1];
	assign mag_c     = neg_c ? (VAL_W'(0) - arg.value) : arg.value;
	assign start     = accept && is_dec;

	ifmt_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.bin    (mag_c),
		.busy   (conv_busy),
		.bcd    (bcd)
	);

	// field plan
	always_comb begin
		nd_c  = 4'd1;
		any_c = 1'b0;
		for (int i = 0; i < NUM_DIG; i++) begin
			if (digits_q[i*4 +: 4] != 4'd0) begin
				nd_c  = 4'(i + 1);
				any_c = 1'b1;
			end
		end
		show_c  = !(dot_q && (p_q == 6'd0) && !any_c);
		len_c   = show_c ? ({3'b0, nd_c} + {6'b0, neg_q}) : '0;
		prec_c  = {1'b0, p_q} + {6'b0, (neg_q && (p_q != 6'd0))};
		zeff_c  = zp_q && !dot_q && !la_q;
		w7      = {1'b0, w_q};
		if (prec_c > len_c) begin
			zeros_c = prec_c - len_c;
		end else if (zeff_c && (w7 > len_c)) begin
			zeros_c = w7 - len_c;
		end else begin
			zeros_c = '0;
		end
		tot_c   = len_c + zeros_c;
		space_c = ((w7 > tot_c) && !zeff_c) ? (w7 - tot_c) : '0;
		rem_c   = tot_c + space_c;
	end

	// emission
	assign emit_st   = (state_q >= S_LSP);
	assign slot_free = !chr_valid_q || chr_ready;
	assign load      = emit_st && (cnt_q != '0) && slot_free;
	assign advance   = emit_st && (cnt_q == '0);
	assign nxt_state = state_q + 3'd1;
	assign dig_idx   = cnt_q[3:0] - 4'd1;

	always_comb begin
		case (nxt_state)
			S_SIGN:  nxt_cnt = {6'b0, neg_q};
			S_ZERO:  nxt_cnt = zeros_q;
			S_DIG:   nxt_cnt = show_q ? {3'b0, ndig_q} : '0;
			S_RSP:   nxt_cnt = la_q ? space_q : '0;
			default: nxt_cnt = '0;
		endcase
	end

	always_comb begin
		case (state_q)
			S_SIGN:  ch = CH_MINUS;
			S_ZERO:  ch = CH_ZERO;
			S_DIG:   ch = digit_char(digits_q[{dig_idx, 2'b00} +: 4], upper_q);
			default: ch = CH_SPACE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			count_q     <= '0;
			chr_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= is_dec ? S_CONV : S_PLAN;
					end
				end
				S_CONV: begin
					if (!conv_busy) begin
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					state_q <= S_LSP;
					cnt_q   <= la_q ? '0 : space_c;
					rem_q   <= rem_c;
				end
				default: begin
					if (advance) begin
						state_q <= (state_q == S_RSP) ? S_IDLE : nxt_state;
						cnt_q   <= nxt_cnt;
					end else if (load) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						rem_q   <= rem_q - CNT_W'(1);
						count_q <= count_q + 32'd1;
					end
				end
			endcase
			if (load) begin
				chr_valid_q <= 1'b1;
			end else if (chr_ready) begin
				chr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= neg_c;
			upper_q <= (arg.conversion == CONV_HEXU);
			w_q     <= (arg.field_width > MAX_FIELD) ? MAX_FIELD : arg.field_width;
			p_q     <= (arg.min_digits > MAX_FIELD) ? MAX_FIELD : arg.min_digits;
			dot_q   <= arg.has_dot;
			zp_q    <= arg.zero_pad;
			la_q    <= arg.left_align;
			if (!is_dec) begin
				digits_q <= {8'h00, mag_c};
			end
		end
		if (state_q == S_CONV && !conv_busy) begin
			digits_q <= bcd;
		end
		if (state_q == S_PLAN) begin
			zeros_q <= zeros_c;
			space_q <= space_c;
			ndig_q  <= nd_c;
			show_q  <= show_c;
		end
		if (load) begin
			chr_q.char_code   <= ch;
			chr_q.last        <= (rem_q == CNT_W'(1));
			chr_q.total_count <= count_q + 32'd1;
		end
	end

	assign chr_valid = chr_valid_q;
	assign chr       = chr_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> chr_valid && (chr.total_count == $past(count_q) + 32'd1))
		else $error("character count out of step");

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_st && (cnt_q != '0)) |-> (rem_q != '0))
		else $error("segment holds characters beyond field length");

	a_rem_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RSP) && (cnt_q == '0)) |-> (rem_q == '0))
		else $error("field closed with characters outstanding");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Integer field formatter testbench
// Drives argument items into the formatter and predicts the formatted ASCII
// field of each one, character by character, with the running count. A short
// directed set covers the edge cases, then constrained-random items run
// through four phases: no stalls, sender idling, receiver stalls and both.
// ----------------------------------------------------------------------------
module tb_top;
	import ifmt_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 37;

	class field_predictor;
		chr_t expected_chars[$];
		logic [31:0] char_count;
		int errors;
		int args_seen;
		int chars_seen;

		function new();
			char_count = '0;
			errors = 0;
			args_seen = 0;
			chars_seen = 0;
		endfunction

		function void predict_field(arg_t a);
			logic [5:0] w;
			logic [5:0] p;
			logic [31:0] mag;
			logic [31:0] radix;
			logic [3:0] digs[10];
			logic [7:0] text[$];
			logic [7:0] letter;
			bit neg;
			bit show;
			bit zeff;
			int ndig;
			int len;
			int prec;
			int zeros;
			int pad;
			chr_t c;
			w = (a.field_width > MAX_FIELD) ? MAX_FIELD : a.field_width;
			p = (a.min_digits > MAX_FIELD) ? MAX_FIELD : a.min_digits;
			neg = (a.conversion == CONV_SDEC) && a.value[31];
			mag = neg ? (32'd0 - a.value) : a.value;
			radix = (a.conversion == CONV_HEXL || a.conversion == CONV_HEXU) ? 32'd16 : 32'd10;
			letter = (a.conversion == CONV_HEXU) ? CH_UPPER : CH_LOWER;
			show = !(a.has_dot && p == 0 && mag == 0);
			ndig = 0;
			do begin
				digs[ndig] = 4'(mag % radix);
				mag = mag / radix;
				ndig++;
			end while (mag != 0 && ndig < 10);
			len = ndig + (neg ? 1 : 0);
			prec = int'(p) + ((neg && p > 0) ? 1 : 0);
			if (!show) len = 0;
			zeff = a.zero_pad && !a.has_dot && !a.left_align;
			if (prec > len) zeros = prec - len;
			else zeros = (zeff && int'(w) > len) ? int'(w) - len : 0;
			len += zeros;
			pad = (int'(w) > len && !zeff) ? int'(w) - len : 0;
			if (!a.left_align) repeat (pad) text.push_back(CH_SPACE);
			if (neg) text.push_back(CH_MINUS);
			repeat (zeros) text.push_back(CH_ZERO);
			if (show)
				for (int i = ndig - 1; i >= 0; i--) begin
					if (digs[i] < 4'd10) text.push_back(CH_ZERO + {4'h0, digs[i]});
					else text.push_back(letter + {4'h0, digs[i]} - 8'd10);
				end
			if (a.left_align) repeat (pad) text.push_back(CH_SPACE);
			foreach (text[i]) begin
				char_count = char_count + 32'd1;
				c.char_code = text[i];
				c.last = (i == text.size() - 1);
				c.total_count = char_count;
				expected_chars.push_back(c);
			end
			args_seen++;
		endfunction

		function void check_char(chr_t got);
			chr_t want;
			chars_seen++;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected char %02h last %0b count %0d", $time,
					got.char_code, got.last, got.total_count);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			if (got.char_code !== want.char_code || got.last !== want.last ||
				got.total_count !== want.total_count) begin
				$display("%0t: char mismatch: expected %02h last %0b count %0d,",
					$time, want.char_code, want.last, want.total_count,
					" got %02h last %0b count %0d",
					got.char_code, got.last, got.total_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic arg_valid = 1'b0;
	logic arg_ready;
	arg_t arg = '0;
	logic chr_valid;
	logic chr_ready = 1'b0;
	chr_t chr;

	int sender_idle_pct = 0;
	int sink_stall_pct = 0;
	int cycle_count = 0;
	field_predictor fields = new();

	integer_field_formatter uut (
		.clk(clk),
		.arst_n(arst_n),
		.arg_valid(arg_valid),
		.arg_ready(arg_ready),
		.arg(arg),
		.chr_valid(chr_valid),
		.chr_ready(chr_ready),
		.chr(chr)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d chars outstanding", cycle_count,
				fields.expected_chars.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && chr_valid && chr_ready) fields.check_char(chr);
			chr_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	function automatic arg_t make_arg(logic [31:0] v, logic [1:0] conv, logic [5:0] w,
		logic [5:0] p, logic dot, logic zp, logic la);
		arg_t a;
		a.value = v;
		a.conversion = conv;
		a.field_width = w;
		a.min_digits = p;
		a.has_dot = dot;
		a.zero_pad = zp;
		a.left_align = la;
		return a;
	endfunction

	function automatic arg_t random_arg();
		arg_t a;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) a.value = $urandom_range(0, 99);
		else if (pick < 45) a.value = $urandom();
		else if (pick < 60) a.value = 32'd0 - $urandom_range(1, 1000);
		else if (pick < 70) begin
			case ($urandom_range(0, 3))
				0: a.value = 32'h0000_0000;
				1: a.value = 32'h8000_0000;
				2: a.value = 32'h7fff_ffff;
				default: a.value = 32'hffff_ffff;
			endcase
		end else a.value = $urandom() >> $urandom_range(0, 31);
		a.conversion = 2'($urandom_range(0, 3));
		a.field_width = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 20)) :
			6'($urandom_range(0, 63));
		a.min_digits = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 14)) :
			6'($urandom_range(0, 63));
		a.has_dot = 1'($urandom_range(0, 1));
		a.zero_pad = 1'($urandom_range(0, 1));
		a.left_align = ($urandom_range(0, 3) == 0);
		return a;
	endfunction

	task automatic send_arg(arg_t a);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			arg_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		arg_valid <= 1'b1;
		arg <= a;
		do @(posedge clk); while (!arg_ready);
		fields.predict_field(a);
	endtask

	task automatic drain();
		arg_valid <= 1'b0;
		do @(posedge clk); while (fields.expected_chars.size() != 0);
	endtask

	initial begin
		arg_t directed[$];
		int idle_plan[4][2];
		idle_plan = '{'{0, 0}, '{65, 0}, '{0, 65}, '{23, 23}};

		directed.push_back(make_arg(32'd0, CONV_SDEC, 6'd0, 6'd0, 1'b1, 1'b0, 1'b0));
		directed.push_back(make_arg(32'd0, CONV_UDEC, 6'd5, 6'd0, 1'b1, 1'b0, 1'b0));
		directed.push_back(make_arg(32'd0, CONV_HEXL, 6'd7, 6'd0, 1'b1, 1'b1, 1'b1));
		directed.push_back(make_arg(32'd0, CONV_SDEC, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
		directed.push_back(make_arg(32'h8000_0000, CONV_SDEC, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
		directed.push_back(make_arg(32'h8000_0000, CONV_SDEC, 6'd14, 6'd0, 1'b0, 1'b1, 1'b0));
		directed.push_back(make_arg(32'h7fff_ffff, CONV_SDEC, 6'd12, 6'd0, 1'b0, 1'b0, 1'b1));
		directed.push_back(make_arg(32'hffff_ffff, CONV_SDEC, 6'd12, 6'd0, 1'b0, 1'b1, 1'b0));
		directed.push_back(make_arg(32'hffff_ffff, CONV_UDEC, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
		directed.push_back(make_arg(32'hffff_ffff, CONV_HEXL, 6'd10, 6'd0, 1'b0, 1'b1, 1'b0));
		directed.push_back(make_arg(32'hdead_beef, CONV_HEXU, 6'd10, 6'd0, 1'b0, 1'b0, 1'b0));
		directed.push_back(make_arg(32'h00ab_cdef, CONV_HEXL, 6'd3, 6'd9, 1'b1, 1'b0, 1'b1));
		directed.push_back(make_arg(32'd0 - 32'd42, CONV_SDEC, 6'd0, 6'd5, 1'b1, 1'b0, 1'b0));
		directed.push_back(make_arg(32'd0 - 32'd42, CONV_SDEC, 6'd9, 6'd5, 1'b1, 1'b1, 1'b0));
		directed.push_back(make_arg(32'd77, CONV_UDEC, 6'd8, 6'd0, 1'b0, 1'b1, 1'b1));
		directed.push_back(make_arg(32'd77, CONV_UDEC, 6'd8, 6'd0, 1'b0, 1'b0, 1'b1));
		directed.push_back(make_arg(32'd0 - 32'd7, CONV_SDEC, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0));
		directed.push_back(make_arg(32'd5, CONV_UDEC, 6'd63, 6'd0, 1'b0, 1'b1, 1'b0));
		directed.push_back(make_arg(32'hffff_ffff, CONV_HEXU, 6'd61, 6'd62, 1'b1, 1'b1, 1'b1));
		directed.push_back(make_arg(32'd0 - 32'd3, CONV_SDEC, 6'd63, 6'd0, 1'b0, 1'b0, 1'b1));
		directed.push_back(make_arg(32'd0, CONV_HEXU, 6'd4, 6'd0, 1'b0, 1'b1, 1'b0));
		directed.push_back(make_arg(32'd1234, CONV_SDEC, 6'd2, 6'd1, 1'b1, 1'b0, 1'b0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_arg(directed[i]);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = idle_plan[ph][0];
			sink_stall_pct = idle_plan[ph][1];
			repeat (RANDOM_PER_PHASE) send_arg(random_arg());
			drain();
		end

		sink_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d argument items (%0d directed) and %0d characters", fields.args_seen,
			directed.size(), fields.chars_seen);
		$display("across phases with no idling, sender gaps, sink stalls and both combined");
		if (fields.errors == 0 && fields.expected_chars.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d chars never arrived", fields.errors,
				fields.expected_chars.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
